[hw/rtl/mf3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 rgb median filter
// Frame limits, counter widths, pixel and column types, register and item codes.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_W = 12;
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
  localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_WD     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RESET_HD     = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
  localparam int RESET_TOTAL  = RESET_WD * RESET_HD;
  localparam int RESET_START  = (RESET_HD - 1) * RESET_WD;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // where an emitted pixel comes from
  typedef enum logic [1:0] {
    SEL_MEDIAN,
    SEL_CENTER,
    SEL_TAIL,
    SEL_STORE
  } sel_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // one raw window column, top row is the oldest line
  typedef struct packed {
    pixel_t bot;
    pixel_t mid;
    pixel_t top;
  } column_t;

  // one column sorted per channel
  typedef struct packed {
    pixel_t hi;
    pixel_t mid;
    pixel_t lo;
  } sorted_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } line_req_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    int vi;
    vi = int'(v);
    if (vi < 3) return 3;
    if (vi > hi) return hi;
    return vi;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mf3_lines.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_lines: the two line stores
// Upper and middle line memories with registered read; a pixel write moves the
// middle entry up and stores the new pixel in the middle line.
// ----------------------------------------------------------------------------
module mf3_lines (
  input  logic                clk,
  input  mf3_pkg::line_req_t  req,
  input  mf3_pkg::pixel_t     wr_px,
  output mf3_pkg::pixel_t     upper_rd,
  output mf3_pkg::pixel_t     middle_rd
);

  mf3_pkg::pixel_t upper_mem  [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pixel_t middle_mem [mf3_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      upper_rd  <= upper_mem[req.rd_addr];
      middle_rd <= middle_mem[req.rd_addr];
    end
  end

  // middle_rd still holds the old entry of the column being written
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      upper_mem[req.wr_addr]  <= middle_rd;
      middle_mem[req.wr_addr] <= wr_px;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mf3_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_cell: one column of the 3x3 window
// Takes the column from its right neighbor on each shift, keeps it raw for the
// next cell and sorted per channel for the median network.
// ----------------------------------------------------------------------------
module mf3_cell (
  input  logic              clk,
  input  logic              shift,
  input  mf3_pkg::column_t  col_in,
  output mf3_pkg::column_t  col_out,
  output mf3_pkg::sorted_t  srt
);

  mf3_pkg::sorted_t srt_next;

  // returns {hi, mid, lo}
  function automatic logic [3*mf3_pkg::CH_W-1:0] sort3(
    input logic [mf3_pkg::CH_W-1:0] a,
    input logic [mf3_pkg::CH_W-1:0] b,
    input logic [mf3_pkg::CH_W-1:0] c
  );
    logic [mf3_pkg::CH_W-1:0] l1, h1, t, lo, md, hi;
    l1 = (a < b) ? a : b;
    h1 = (a < b) ? b : a;
    lo = (l1 < c) ? l1 : c;
    t  = (l1 < c) ? c : l1;
    md = (t < h1) ? t : h1;
    hi = (t < h1) ? h1 : t;
    return {hi, md, lo};
  endfunction

  always_comb begin
    {srt_next.hi.red, srt_next.mid.red, srt_next.lo.red} =
      sort3(col_in.top.red, col_in.mid.red, col_in.bot.red);
    {srt_next.hi.green, srt_next.mid.green, srt_next.lo.green} =
      sort3(col_in.top.green, col_in.mid.green, col_in.bot.green);
    {srt_next.hi.blue, srt_next.mid.blue, srt_next.lo.blue} =
      sort3(col_in.top.blue, col_in.mid.blue, col_in.bot.blue);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
      srt     <= srt_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mf3_median.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_median: median of nine from three sorted columns
// Max of lows, median of middles and min of highs, then the median of those.
// ----------------------------------------------------------------------------
module mf3_median (
  input  mf3_pkg::sorted_t  col0,
  input  mf3_pkg::sorted_t  col1,
  input  mf3_pkg::sorted_t  col2,
  output mf3_pkg::pixel_t   med
);

  function automatic logic [mf3_pkg::CH_W-1:0] min2(
    input logic [mf3_pkg::CH_W-1:0] a,
    input logic [mf3_pkg::CH_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic [mf3_pkg::CH_W-1:0] max2(
    input logic [mf3_pkg::CH_W-1:0] a,
    input logic [mf3_pkg::CH_W-1:0] b
  );
    return (a < b) ? b : a;
  endfunction

  function automatic logic [mf3_pkg::CH_W-1:0] med3(
    input logic [mf3_pkg::CH_W-1:0] a,
    input logic [mf3_pkg::CH_W-1:0] b,
    input logic [mf3_pkg::CH_W-1:0] c
  );
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic logic [mf3_pkg::CH_W-1:0] chan_median(
    input logic [mf3_pkg::CH_W-1:0] l0, l1, l2,
    input logic [mf3_pkg::CH_W-1:0] m0, m1, m2,
    input logic [mf3_pkg::CH_W-1:0] h0, h1, h2
  );
    logic [mf3_pkg::CH_W-1:0] lo_max, mid_med, hi_min;
    lo_max  = max2(max2(l0, l1), l2);
    mid_med = med3(m0, m1, m2);
    hi_min  = min2(min2(h0, h1), h2);
    return med3(lo_max, mid_med, hi_min);
  endfunction

  always_comb begin
    med.red = chan_median(col0.lo.red, col1.lo.red, col2.lo.red,
                          col0.mid.red, col1.mid.red, col2.mid.red,
                          col0.hi.red, col1.hi.red, col2.hi.red);
    med.green = chan_median(col0.lo.green, col1.lo.green, col2.lo.green,
                            col0.mid.green, col1.mid.green, col2.mid.green,
                            col0.hi.green, col1.hi.green, col2.hi.green);
    med.blue = chan_median(col0.lo.blue, col1.lo.blue, col2.lo.blue,
                           col0.mid.blue, col1.mid.blue, col2.mid.blue,
                           col0.hi.blue, col1.hi.blue, col2.hi.blue);
  end

endmodule
`default_nettype wire

[hw/rtl/median_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb: 3x3 median filter for a raster rgb pixel stream
// Line stores, a chain of three window column cells and a median network.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the output stalls and gives each
// pixel back in raster order, interior pixels replaced per channel by the median
// of their 3x3 neighborhood and border pixels unchanged. A pixel leaves one line
// plus one pixel (in items) after it entered; the last frame_width+1 pixels of a
// frame leave through drain items (tuser high), one per item, the final one with
// tlast. An emitted pixel passes both stages to the output register. This rate
// is set by the window cell chain, which shifts one column per pixel, and by the
// line stores, which take one read and one write per clock. Writing either frame
// register restarts the frame. The line stores have no clearing pass; entries
// are valid once the first lines of a frame have been written.
module median_filter_3x3_rgb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mf3_pkg::PIX_W-1:0]     s_tdata,   // red_in, green_in, blue_in
  input  logic                          s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mf3_pkg::PIX_W-1:0]     m_tdata,   // red_out, green_out, blue_out
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_data
);

  // frame geometry
  logic [mf3_pkg::WD_W-1:0]  wd;
  logic [mf3_pkg::HD_W-1:0]  hd;
  logic [mf3_pkg::IDX_W-1:0] total;
  logic [mf3_pkg::IDX_W-1:0] start;
  logic [mf3_pkg::WD_W-1:0]  wd_next;
  logic [mf3_pkg::HD_W-1:0]  hd_next;

  // stream position
  logic [mf3_pkg::COL_W-1:0] col;
  logic [mf3_pkg::ROW_W-1:0] row;
  logic [mf3_pkg::IDX_W-1:0] oidx;

  // input decode
  logic                      accept;
  mf3_pkg::pixel_t           in_px;
  mf3_pkg::op_t              in_op;
  logic [mf3_pkg::COL_W-1:0] c_eff;
  logic [mf3_pkg::ROW_W-1:0] r_eff;
  logic [mf3_pkg::WD_W-1:0]  c_inc;
  logic [mf3_pkg::HD_W-1:0]  r_inc;
  logic [mf3_pkg::COL_W-1:0] col_next;
  logic [mf3_pkg::ROW_W-1:0] row_next;
  logic                      at_origin;
  logic                      r_ge2;
  logic                      px_emit;
  logic [mf3_pkg::IDX_W-1:0] o_inc;
  logic                      o_last;
  logic                      drain_ok;
  logic [mf3_pkg::COL_W-1:0] drain_addr;
  logic                      item_ok;
  logic                      emit_in;
  mf3_pkg::sel_t             sel_in;

  // first stage: line store read in flight
  logic                      valid1;
  logic                      emit1;
  mf3_pkg::sel_t             sel1;
  logic                      last1;
  logic                      wr1;
  logic [mf3_pkg::COL_W-1:0] col1;
  mf3_pkg::pixel_t           px1;

  // second stage: window holds the item
  logic                      valid2;
  mf3_pkg::sel_t             sel2;
  logic                      last2;
  mf3_pkg::pixel_t           val2;

  logic                      out_free;
  logic                      move1;
  logic                      move2;
  logic                      adv2;
  logic                      shift;

  mf3_pkg::line_req_t        lreq;
  mf3_pkg::pixel_t           upper_rd;
  mf3_pkg::pixel_t           middle_rd;
  mf3_pkg::column_t          col_new;
  mf3_pkg::column_t          raw1;
  mf3_pkg::column_t          raw2;
  mf3_pkg::sorted_t          srt0;
  mf3_pkg::sorted_t          srt1;
  mf3_pkg::sorted_t          srt2;
  mf3_pkg::pixel_t           med;
  mf3_pkg::pixel_t           out_px;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;
  assign move2    = valid2 && out_free;
  assign adv2     = !valid2 || out_free;
  assign move1    = valid1 && adv2;
  assign s_tready = !rst && (!valid1 || adv2);
  assign accept   = s_tvalid && s_tready;
  assign shift    = move1 && wr1;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_px = mf3_pkg::pixel_t'(s_tdata);
    in_op = mf3_pkg::op_t'(s_tuser);

    c_eff = (mf3_pkg::WD_W'(col) >= wd) ? '0 : col;
    r_eff = (mf3_pkg::HD_W'(row) >= hd) ? '0 : row;
    c_inc = mf3_pkg::WD_W'(c_eff) + mf3_pkg::WD_W'(1);
    r_inc = mf3_pkg::HD_W'(r_eff) + mf3_pkg::HD_W'(1);

    if (c_inc >= wd) begin
      col_next = '0;
      row_next = (r_inc >= hd) ? '0 : mf3_pkg::ROW_W'(r_inc);
    end else begin
      col_next = mf3_pkg::COL_W'(c_inc);
      row_next = r_eff;
    end

    at_origin = (c_eff == '0) && (r_eff == '0);
    r_ge2     = r_eff >= mf3_pkg::ROW_W'(2);
    px_emit   = r_ge2 || ((r_eff == mf3_pkg::ROW_W'(1)) && (c_eff != '0));

    o_inc  = oidx + mf3_pkg::IDX_W'(1);
    o_last = o_inc == total;

    // drains only count once the input sits at the start of a frame
    drain_ok   = (col == '0) && (row == '0) && (oidx != '0) && (oidx < total);
    drain_addr = mf3_pkg::COL_W'(oidx - start);

    unique case (in_op)
      mf3_pkg::OP_PIXEL: begin
        item_ok = 1'b1;
        emit_in = px_emit;
        sel_in  = (r_ge2 && (c_eff >= mf3_pkg::COL_W'(2))) ?
                  mf3_pkg::SEL_MEDIAN : mf3_pkg::SEL_CENTER;
      end
      mf3_pkg::OP_DRAIN: begin
        item_ok = drain_ok;
        emit_in = 1'b1;
        // the pixel before the last row is the newest column's middle entry
        sel_in  = (oidx >= start) ? mf3_pkg::SEL_STORE : mf3_pkg::SEL_TAIL;
      end
      default: begin
        item_ok = 1'b0;
        emit_in = 1'b0;
        sel_in  = mf3_pkg::SEL_CENTER;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // frame registers and position
  // ---------------------------------------------------------------------------
  always_comb begin
    wd_next = wd;
    hd_next = hd;
    unique case (mf3_pkg::reg_idx_t'(cfg_index))
      mf3_pkg::REG_FRAME_WIDTH:
        wd_next = mf3_pkg::WD_W'(mf3_pkg::clamp_dim(cfg_data, mf3_pkg::MAX_WIDTH));
      mf3_pkg::REG_FRAME_HEIGHT:
        hd_next = mf3_pkg::HD_W'(mf3_pkg::clamp_dim(cfg_data, mf3_pkg::MAX_HEIGHT));
      default: begin
        wd_next = wd;
        hd_next = hd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wd    <= mf3_pkg::WD_W'(mf3_pkg::RESET_WD);
      hd    <= mf3_pkg::HD_W'(mf3_pkg::RESET_HD);
      total <= mf3_pkg::IDX_W'(mf3_pkg::RESET_TOTAL);
      start <= mf3_pkg::IDX_W'(mf3_pkg::RESET_START);
      col   <= '0;
      row   <= '0;
      oidx  <= '0;
    end else if (cfg_we) begin
      wd    <= wd_next;
      hd    <= hd_next;
      total <= mf3_pkg::IDX_W'(wd_next) * mf3_pkg::IDX_W'(hd_next);
      start <= mf3_pkg::IDX_W'(wd_next) *
               (mf3_pkg::IDX_W'(hd_next) - mf3_pkg::IDX_W'(1));
      col   <= '0;
      row   <= '0;
      oidx  <= '0;
    end else if (accept) begin
      if (in_op == mf3_pkg::OP_PIXEL) begin
        col <= col_next;
        row <= row_next;
        if (at_origin) begin
          oidx <= '0;
        end else if (px_emit) begin
          oidx <= o_inc;
        end
      end else if (drain_ok) begin
        oidx <= o_last ? '0 : o_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // first stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= item_ok;
    end else if (move1) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit1 <= emit_in;
      sel1  <= sel_in;
      last1 <= o_last;
      wr1   <= in_op == mf3_pkg::OP_PIXEL;
      col1  <= c_eff;
      px1   <= in_px;
    end
  end

  always_comb begin
    lreq.rd_en   = accept;
    lreq.rd_addr = (in_op == mf3_pkg::OP_PIXEL) ? c_eff : drain_addr;
    lreq.wr_en   = shift;
    lreq.wr_addr = col1;
  end

  mf3_lines u_lines (
    .clk       (clk),
    .req       (lreq),
    .wr_px     (px1),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd)
  );

  // ---------------------------------------------------------------------------
  // window: newest column enters at cell 2
  // ---------------------------------------------------------------------------
  always_comb begin
    col_new.top = upper_rd;
    col_new.mid = middle_rd;
    col_new.bot = px1;
  end

  mf3_cell u_cell2 (
    .clk     (clk),
    .shift   (shift),
    .col_in  (col_new),
    .col_out (raw2),
    .srt     (srt2)
  );

  mf3_cell u_cell1 (
    .clk     (clk),
    .shift   (shift),
    .col_in  (raw2),
    .col_out (raw1),
    .srt     (srt1)
  );

  mf3_cell u_cell0 (
    .clk     (clk),
    .shift   (shift),
    .col_in  (raw1),
    .col_out (),
    .srt     (srt0)
  );

  mf3_median u_median (
    .col0 (srt0),
    .col1 (srt1),
    .col2 (srt2),
    .med  (med)
  );

  // ---------------------------------------------------------------------------
  // second stage and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (move1) begin
      valid2 <= emit1;
    end else if (move2) begin
      valid2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      sel2  <= sel1;
      last2 <= last1;
      val2  <= middle_rd;
    end
  end

  always_comb begin
    unique case (sel2)
      mf3_pkg::SEL_MEDIAN: out_px = med;
      mf3_pkg::SEL_CENTER: out_px = raw1.mid;
      mf3_pkg::SEL_TAIL:   out_px = raw2.mid;
      mf3_pkg::SEL_STORE:  out_px = val2;
      default:             out_px = val2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      m_tdata <= out_px;
      m_tlast <= last2;
    end
  end

endmodule
`default_nettype wire

[tb/tb_median_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_rgb: self-checking bench for the 3x3 rgb median filter
// Streams raster frames of random pixels with drain items, random gaps and
// output stalls, and checks every output pixel against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_rgb;

  localparam int CLK_HALF    = 4;
  localparam int HOLD_CYCLES = 8;
  localparam int RAND_ITEMS  = 730;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    mf3_pkg::pixel_t px;
    logic            last;
  } filtered_pixel_t;

  // tracks line stores, window and frame position, queues expected pixels
  class median_predictor;
    mf3_pkg::pixel_t upper_line[mf3_pkg::MAX_WIDTH];
    mf3_pkg::pixel_t middle_line[mf3_pkg::MAX_WIDTH];
    mf3_pkg::pixel_t win[3][3];
    logic [mf3_pkg::CFG_W-1:0] width_reg;
    logic [mf3_pkg::CFG_W-1:0] height_reg;
    int unsigned col;
    int unsigned row;
    int unsigned out_idx;
    filtered_pixel_t pending_pixels[$];
    int errors;
    int checked;
    int frame_ends;

    function new();
      width_reg  = mf3_pkg::CFG_W'(mf3_pkg::RESET_WIDTH);
      height_reg = mf3_pkg::CFG_W'(mf3_pkg::RESET_HEIGHT);
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
      out_idx = 0;
      errors = 0;
      checked = 0;
      frame_ends = 0;
    endfunction

    function int unsigned eff_dim(logic [mf3_pkg::CFG_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function int unsigned eff_width();
      return eff_dim(width_reg, mf3_pkg::MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return eff_dim(height_reg, mf3_pkg::MAX_HEIGHT);
    endfunction

    function void set_reg(mf3_pkg::reg_idx_t idx, logic [mf3_pkg::CFG_W-1:0] val);
      if (idx == mf3_pkg::REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      col = 0;
      row = 0;
      out_idx = 0;
    endfunction

    function logic [mf3_pkg::CH_W-1:0] channel_median(int lsb);
      logic [mf3_pkg::CH_W-1:0] v[9];
      logic [mf3_pkg::CH_W-1:0] x;
      int i, j, k;
      k = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          v[k] = win[i][j][lsb +: mf3_pkg::CH_W];
          k++;
        end
      end
      for (i = 1; i < 9; i++) begin
        x = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > x) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = x;
      end
      return v[4];
    endfunction

    // returns 1 when the item produces an output pixel
    function bit accept_item(mf3_pkg::op_t op, mf3_pkg::pixel_t px);
      int unsigned w, h, total, c, r, start;
      int i;
      filtered_pixel_t e;
      w = eff_width();
      h = eff_height();
      total = w * h;
      if (op == mf3_pkg::OP_PIXEL) begin
        c = (col >= w) ? 0 : col;
        r = (row >= h) ? 0 : row;
        if (r == 0 && c == 0) out_idx = 0;
        for (i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = px;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px;
        if (c + 1 >= w) begin
          col = 0;
          row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          col = c + 1;
          row = r;
        end
        // nothing leaves until one line plus one pixel has come in
        if (!(r >= 2 || (r == 1 && c >= 1))) return 0;
        if (r >= 2 && c >= 2) begin
          e.px.red   = channel_median(0);
          e.px.green = channel_median(mf3_pkg::CH_W);
          e.px.blue  = channel_median(2 * mf3_pkg::CH_W);
        end else begin
          e.px = win[1][1];
        end
        e.last = (out_idx + 1 == total);
        out_idx++;
        pending_pixels = {pending_pixels, e};
        return 1;
      end
      // drain only counts once the whole frame is in and pixels are pending
      if (col != 0 || row != 0 || out_idx == 0 || out_idx >= total) return 0;
      start = (h - 1) * w;
      e.px = (out_idx >= start) ? middle_line[out_idx - start] : upper_line[w - 1];
      e.last = (out_idx + 1 == total);
      out_idx = e.last ? 0 : out_idx + 1;
      pending_pixels = {pending_pixels, e};
      return 1;
    endfunction

    function void compare_field(string name, logic [mf3_pkg::CH_W-1:0] exp_v,
                                logic [mf3_pkg::CH_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(mf3_pkg::pixel_t px, logic last);
      filtered_pixel_t e;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: output pixel with none expected, actual %h last %b", $time, px, last);
        return;
      end
      e = pending_pixels.pop_front();
      checked++;
      if (e.last) frame_ends++;
      compare_field("red", e.px.red, px.red);
      compare_field("green", e.px.green, px.green);
      compare_field("blue", e.px.blue, px.blue);
      compare_field("frame end", mf3_pkg::CH_W'(e.last), mf3_pkg::CH_W'(last));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [mf3_pkg::PIX_W-1:0]   s_tdata = '0;    // red_in, green_in, blue_in
  logic                        s_tuser = 1'b0;  // op
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [mf3_pkg::PIX_W-1:0]   m_tdata;         // red_out, green_out, blue_out
  logic                        m_tlast;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [mf3_pkg::CFG_W-1:0]   cfg_data = '0;

  median_predictor sb;
  bit     tx_idle_on = 1'b0;
  bit     rx_stall_on = 1'b0;
  bit     need_restart = 1'b0;
  bit     paused_once = 1'b0;
  int     stall_left = 0;
  longint cycles = 0;
  int     useful_items = 0;
  int     item_goal = 0;
  int     n_pixels = 0;
  int     n_drains = 0;
  int     n_frames = 0;
  int     n_writes = 0;

  median_filter_3x3_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: check each transfer, stall ready at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(mf3_pkg::pixel_t'(m_tdata), m_tlast);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                 : $urandom_range(5, 40);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (!tx_idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mf3_pkg::pixel_t rand_pixel();
    mf3_pkg::pixel_t p;
    p = mf3_pkg::pixel_t'(mf3_pkg::PIX_W'($urandom));
    // saturated channels now and then
    if ($urandom_range(0, 4) == 0) begin
      p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  // mostly small frames, a few clamped or wider ones
  function automatic logic [mf3_pkg::CFG_W-1:0] pick_dim(int typ_hi, int big_hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return mf3_pkg::CFG_W'($urandom_range(3, typ_hi));
    if (roll < 95) return mf3_pkg::CFG_W'($urandom_range(0, 2));
    return mf3_pkg::CFG_W'($urandom_range(typ_hi + 1, big_hi));
  endfunction

  task automatic send_item(input mf3_pkg::op_t op, input mf3_pkg::pixel_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    if (sb.accept_item(op, px) || op == mf3_pkg::OP_PIXEL) useful_items++;
    if (op == mf3_pkg::OP_PIXEL) n_pixels++;
    else n_drains++;
  endtask

  // hold off input until every expected pixel is out and the pipe is empty
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mf3_pkg::reg_idx_t idx,
                           input logic [mf3_pkg::CFG_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  task automatic run_frame(input int npix, input int ndrain, input int noise_pct,
                           input bit pause);
    int i;
    for (i = 0; i < npix; i++) begin
      if (pause && i == npix / 2) begin
        wait_drained();
        paused_once = 1'b1;
      end
      send_item(mf3_pkg::OP_PIXEL, rand_pixel());
      // mid-frame drain, must be ignored
      if (i < npix - 1 && $urandom_range(0, 99) < noise_pct) begin
        send_item(mf3_pkg::OP_DRAIN, rand_pixel());
      end
    end
    for (i = 0; i < ndrain; i++) send_item(mf3_pkg::OP_DRAIN, rand_pixel());
    n_frames++;
  endtask

  task automatic random_phase();
    int unsigned w, h;
    int frames, f, kind, noise;
    bit pause;
    tx_idle_on  = ($urandom_range(0, 3) != 0);
    rx_stall_on = ($urandom_range(0, 3) != 0);
    if (need_restart || $urandom_range(0, 9) < 6) begin
      if ($urandom_range(0, 1)) begin
        write_reg(mf3_pkg::REG_FRAME_WIDTH, pick_dim(9, 40));
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, pick_dim(6, 10));
      end else begin
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, pick_dim(6, 10));
        if ($urandom_range(0, 1)) write_reg(mf3_pkg::REG_FRAME_WIDTH, pick_dim(9, 40));
      end
      need_restart = 1'b0;
    end
    w = sb.eff_width();
    h = sb.eff_height();
    frames = $urandom_range(1, 3);
    for (f = 0; f < frames; f++) begin
      if (useful_items >= item_goal) break;
      kind  = $urandom_range(0, 9);
      noise = ($urandom_range(0, 3) == 0) ? 10 : 0;
      pause = !paused_once || ($urandom_range(0, 9) == 0);
      if (kind <= 6) begin
        // full frame, full drain, maybe a few drains with nothing left
        run_frame(w * h, w + 1 + $urandom_range(0, 2), noise, pause);
      end else if (kind <= 8) begin
        // next frame drops whatever was not drained
        run_frame(w * h, $urandom_range(0, w), noise, pause);
      end else begin
        run_frame($urandom_range(1, w * h - 1), 0, noise, pause);
        need_restart = 1'b1;
        break;
      end
    end
  endtask

  initial begin
    int i;
    mf3_pkg::pixel_t p;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 640x480 geometry: too few pixels for any output
    for (i = 0; i < 6; i++) send_item(mf3_pkg::OP_PIXEL, rand_pixel());
    send_item(mf3_pkg::OP_DRAIN, '0);

    // undersized registers clamp to a 3x3 frame
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 12'd0);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 12'd2);
    for (i = 0; i < 9; i++) begin
      p.red   = 8'(i * 29);
      p.green = ~8'(i * 29);
      p.blue  = i[0] ? 8'hFF : 8'h00;
      send_item(mf3_pkg::OP_PIXEL, p);
      if (i == 3) send_item(mf3_pkg::OP_DRAIN, '1);
    end
    for (i = 0; i < 5; i++) send_item(mf3_pkg::OP_DRAIN, '0);
    need_restart = 1'b1;

    item_goal = useful_items + RAND_ITEMS;
    while (useful_items < item_goal) random_phase();

    wait_drained();
    $display("sent %0d pixel and %0d drain transfers in %0d frames, %0d register writes",
             n_pixels, n_drains, n_frames, n_writes);
    $display("checked %0d output pixels, %0d frame ends, %0d mismatches",
             sb.checked, sb.frame_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_lines.sv
hw/rtl/mf3_cell.sv
hw/rtl/mf3_median.sv
hw/rtl/median_filter_3x3_rgb.sv
tb/tb_median_filter_3x3_rgb.sv
